>>> hdl/vlsu_pkg.sv
// ----------------------------------------------------------------------------
// vlsu_pkg
// Shared constants, command codes, per-step plan function and the
// controller/datapath interface structs of the vector load/store unit.
// ----------------------------------------------------------------------------
package vlsu_pkg;

   localparam int DMEM_BYTES = 4096;
   localparam int DMEM_AW    = $clog2(DMEM_BYTES);
   localparam int VREG_COUNT = 32;
   localparam int VREG_AW    = $clog2(VREG_COUNT);

   // command codes
   localparam logic [4:0] CMD_LB     = 5'd0;
   localparam logic [4:0] CMD_LH     = 5'd1;
   localparam logic [4:0] CMD_LW     = 5'd2;
   localparam logic [4:0] CMD_SB     = 5'd3;
   localparam logic [4:0] CMD_SH     = 5'd4;
   localparam logic [4:0] CMD_SW     = 5'd5;
   localparam logic [4:0] CMD_LBV    = 5'd6;
   localparam logic [4:0] CMD_LSV    = 5'd7;
   localparam logic [4:0] CMD_LLV    = 5'd8;
   localparam logic [4:0] CMD_LDV    = 5'd9;
   localparam logic [4:0] CMD_LQV    = 5'd10;
   localparam logic [4:0] CMD_LRV    = 5'd11;
   localparam logic [4:0] CMD_LPV    = 5'd12;
   localparam logic [4:0] CMD_LUV    = 5'd13;
   localparam logic [4:0] CMD_LHV    = 5'd14;
   localparam logic [4:0] CMD_LFV    = 5'd15;
   localparam logic [4:0] CMD_LTV    = 5'd16;
   localparam logic [4:0] CMD_SBV    = 5'd17;
   localparam logic [4:0] CMD_SSV    = 5'd18;
   localparam logic [4:0] CMD_SLV    = 5'd19;
   localparam logic [4:0] CMD_SDV    = 5'd20;
   localparam logic [4:0] CMD_SQV    = 5'd21;
   localparam logic [4:0] CMD_SRV    = 5'd22;
   localparam logic [4:0] CMD_SPV    = 5'd23;
   localparam logic [4:0] CMD_SUV    = 5'd24;
   localparam logic [4:0] CMD_SHV    = 5'd25;
   localparam logic [4:0] CMD_SFV    = 5'd26;
   localparam logic [4:0] CMD_STV    = 5'd27;
   localparam logic [4:0] CMD_SWV    = 5'd28;
   localparam logic [4:0] CMD_VWRITE = 5'd29;
   localparam logic [4:0] CMD_VREAD  = 5'd30;

   // byte step modes
   localparam logic [2:0] M_LD_SCALAR = 3'd0;
   localparam logic [2:0] M_LD_BYTE   = 3'd1;
   localparam logic [2:0] M_LD_HALF8  = 3'd2;
   localparam logic [2:0] M_LD_HALF7  = 3'd3;
   localparam logic [2:0] M_ST_DATA   = 3'd4;
   localparam logic [2:0] M_ST_BYTE   = 3'd5;
   localparam logic [2:0] M_ST_SHL    = 3'd6;
   localparam logic [2:0] M_ST_ZERO   = 3'd7;

   typedef struct packed {
      logic               act;
      logic               rd;
      logic               wr;
      logic [2:0]         mode;
      logic [DMEM_AW-1:0] maddr;
      logic [3:0]         bidx;
      logic               en_hi;
      logic               en_lo;
      logic [VREG_AW-1:0] row;
   } step_plan_type;

   typedef struct packed {
      logic               clr_en;
      logic [DMEM_AW-1:0] clr_addr;
      logic               accept;
      logic               row_rd;
      logic               row_cap;
      logic               step;
      logic               apply;
      logic               wb;
      logic               fin_rd;
      logic               fin_cap;
      logic [3:0]         s;
   } ctrl_cmd_type;

   typedef struct packed {
      logic act;
      logic rd;
      logic wb_need;
      logic multi_row;
   } ctrl_sts_type;

   // fourth-store halfword selects, four nibbles per element; 8 means zero
   function automatic logic [15:0] fourth_row(input logic [3:0] e);
      logic [15:0] v;
      case (e)
         4'd0:    v = 16'h0123;
         4'd1:    v = 16'h6745;
         4'd4:    v = 16'h1230;
         4'd5:    v = 16'h7456;
         4'd8:    v = 16'h4567;
         4'd11:   v = 16'h3012;
         4'd12:   v = 16'h5674;
         4'd15:   v = 16'h0123;
         default: v = 16'h8888;
      endcase
      return v;
   endfunction

   // fourth-load offsets for halfwords one to seven
   function automatic logic [3:0] fourth_plus(input logic [2:0] i);
      logic [3:0] v;
      case (i)
         3'd1:    v = 4'd4;
         3'd2:    v = 4'd8;
         3'd3:    v = 4'd12;
         3'd4:    v = 4'd8;
         3'd5:    v = 4'd12;
         3'd7:    v = 4'd4;
         default: v = 4'd0;
      endcase
      return v;
   endfunction

   // one byte step s of a command: memory address, register byte, row, mode
   function automatic step_plan_type step_plan(input logic [4:0] cmd,
                                               input logic [DMEM_AW-1:0] a,
                                               input logic [4:0] r,
                                               input logic [3:0] e,
                                               input logic [3:0] s);
      step_plan_type p;
      logic [DMEM_AW-1:0] al8;
      logic [DMEM_AW-1:0] al16;
      logic [3:0] mis4;
      logic [3:0] m16;
      logic [3:0] e2;
      logic [3:0] off;
      logic [3:0] c;
      logic [3:0] sel;
      logic [4:0] se;
      logic [4:0] sm;
      logic [4:0] e8;
      logic [4:0] bh;
      logic [4:0] bl;
      logic [15:0] frow;
      logic [2:0] i3;
      al8  = {a[DMEM_AW-1:3], 3'b000};
      al16 = {a[DMEM_AW-1:4], 4'b0000};
      mis4 = {1'b0, a[2:0]};
      m16  = a[3:0];
      e2   = {e[3:1], 1'b0};
      se   = {1'b0, e} + {1'b0, s};
      sm   = {1'b0, m16} + {1'b0, s};
      e8   = {1'b0, e} + 5'd8;
      i3   = s[2:0];
      bh   = {1'b0, i3, 1'b0};
      bl   = {1'b0, i3, 1'b1};
      off  = 4'd0;
      c    = e + s;
      frow = fourth_row(e);
      sel  = frow[4'd15 - {s[1:0], 2'b00} -: 4];
      p        = '0;
      p.row    = r[VREG_AW-1:0];
      p.en_hi  = 1'b1;
      p.en_lo  = 1'b1;
      p.maddr  = a + DMEM_AW'(s);
      p.bidx   = e + s;
      p.rd     = (cmd inside {[CMD_LB:CMD_LW], [CMD_LBV:CMD_LTV]});
      p.wr     = (cmd inside {[CMD_SB:CMD_SW], [CMD_SBV:CMD_SWV]});
      case (cmd)
         CMD_LB: begin
            p.act = (s == 4'd0);  p.mode = M_LD_SCALAR;
         end
         CMD_LH: begin
            p.act = (s < 4'd2);   p.mode = M_LD_SCALAR;
         end
         CMD_LW: begin
            p.act = (s < 4'd4);   p.mode = M_LD_SCALAR;
         end
         CMD_SB: begin
            p.act = (s == 4'd0);  p.mode = M_ST_DATA; p.bidx = 4'd0;
         end
         CMD_SH: begin
            p.act = (s < 4'd2);   p.mode = M_ST_DATA; p.bidx = 4'd1 - s;
         end
         CMD_SW: begin
            p.act = (s < 4'd4);   p.mode = M_ST_DATA; p.bidx = 4'd3 - s;
         end
         CMD_LBV: begin
            p.act = (s == 4'd0);  p.mode = M_LD_BYTE;
         end
         CMD_LSV: begin
            p.act = (s < 4'd2) && (se < 5'd16);  p.mode = M_LD_BYTE;
         end
         CMD_LLV: begin
            p.act = (s < 4'd4) && (se < 5'd16);  p.mode = M_LD_BYTE;
         end
         CMD_LDV: begin
            p.act = (s < 4'd8) && (se < 5'd16);  p.mode = M_LD_BYTE;
         end
         CMD_LQV: begin
            p.act = (sm < 5'd16) && (se < 5'd16); p.mode = M_LD_BYTE;
         end
         CMD_LRV: begin
            p.act   = (s >= e) && (s < m16);
            p.mode  = M_LD_BYTE;
            p.bidx  = s - m16;
            off     = s - e;
            p.maddr = al16 + DMEM_AW'(off);
         end
         CMD_LPV, CMD_LUV: begin
            p.act   = (s < 4'd8);
            p.mode  = (cmd == CMD_LPV) ? M_LD_HALF8 : M_LD_HALF7;
            off     = {1'b0, i3} + mis4 - e;
            p.maddr = al8 + DMEM_AW'(off);
            p.bidx  = {i3, 1'b0};
         end
         CMD_LHV: begin
            p.act   = (s < 4'd8);
            p.mode  = M_LD_HALF7;
            off     = mis4 - e + {i3, 1'b0};
            p.maddr = al8 + DMEM_AW'(off);
            p.bidx  = {i3, 1'b0};
         end
         CMD_LFV: begin
            p.act   = (s < 4'd8);
            p.mode  = M_LD_HALF7;
            off     = (i3 == 3'd0) ? (mis4 + e) : (mis4 + fourth_plus(i3) - e);
            p.maddr = al8 + DMEM_AW'(off);
            p.bidx  = {i3, 1'b0};
            p.en_hi = (bh >= {1'b0, e}) && (bh < e8);
            p.en_lo = (bl >= {1'b0, e}) && (bl < e8);
         end
         CMD_LTV: begin
            p.act   = 1'b1;
            p.mode  = M_LD_BYTE;
            p.row   = {r[VREG_AW-1:3], 3'(e[3:1] + s[3:1])};
            p.bidx  = s;
            off     = e + {a[3], 3'b000} + s;
            p.maddr = al8 + DMEM_AW'(off);
         end
         CMD_SBV: begin
            p.act = (s == 4'd0);  p.mode = M_ST_BYTE;
         end
         CMD_SSV: begin
            p.act = (s < 4'd2);   p.mode = M_ST_BYTE;
         end
         CMD_SLV: begin
            p.act = (s < 4'd4);   p.mode = M_ST_BYTE;
         end
         CMD_SDV: begin
            p.act = (s < 4'd8);   p.mode = M_ST_BYTE;
         end
         CMD_SQV: begin
            p.act = (sm < 5'd16); p.mode = M_ST_BYTE;
         end
         CMD_SRV: begin
            p.act   = (s < m16);
            p.mode  = M_ST_BYTE;
            p.maddr = al16 + DMEM_AW'(s);
            p.bidx  = e + s - m16;
         end
         CMD_SPV, CMD_SUV: begin
            p.act  = (s < 4'd8);
            p.bidx = {c[2:0], 1'b0};
            p.mode = ((!c[3]) == (cmd == CMD_SPV)) ? M_ST_BYTE : M_ST_SHL;
         end
         CMD_SHV: begin
            p.act   = (s < 4'd8);
            p.mode  = M_ST_SHL;
            off     = mis4 + {i3, 1'b0};
            p.maddr = al8 + DMEM_AW'(off);
            p.bidx  = {i3, 1'b0} + e;
         end
         CMD_SFV: begin
            p.act   = (s < 4'd4);
            p.mode  = sel[3] ? M_ST_ZERO : M_ST_SHL;
            off     = mis4 + {s[1:0], 2'b00};
            p.maddr = al8 + DMEM_AW'(off);
            p.bidx  = {sel[2:0], 1'b0};
         end
         CMD_STV: begin
            p.act   = 1'b1;
            p.mode  = M_ST_BYTE;
            p.row   = {r[VREG_AW-1:3], s[3:1]};
            p.bidx  = s - e2;
            off     = mis4 - e2 + s;
            p.maddr = al8 + DMEM_AW'(off);
         end
         CMD_SWV: begin
            p.act   = 1'b1;
            p.mode  = M_ST_BYTE;
            off     = mis4 + s;
            p.maddr = al8 + DMEM_AW'(off);
         end
         default: begin
            p.act = 1'b0;
         end
      endcase
      return p;
   endfunction

endpackage

>>> hdl/vlsu_ctrl.sv
// ----------------------------------------------------------------------------
// vlsu_ctrl
// Sequencer of the load/store unit: clearing sweep after reset, row fetch,
// sixteen byte steps, row write-back, final row read and the result word.
// ----------------------------------------------------------------------------
module vlsu_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  vlsu_pkg::ctrl_sts_type sts,
   output vlsu_pkg::ctrl_cmd_type cmd
);

   localparam logic [3:0] S_CLEAR   = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_ROW_RD  = 4'd2;
   localparam logic [3:0] S_ROW_CAP = 4'd3;
   localparam logic [3:0] S_STEP    = 4'd4;
   localparam logic [3:0] S_APPLY   = 4'd5;
   localparam logic [3:0] S_WB      = 4'd6;
   localparam logic [3:0] S_FIN_RD  = 4'd7;
   localparam logic [3:0] S_FIN_CAP = 4'd8;

   logic [3:0]                  state_ff, state_in;
   logic [3:0]                  step_ff, step_in;
   logic [vlsu_pkg::DMEM_AW-1:0] clr_ff, clr_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        pass_end;
   logic [3:0]                  adv_state;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      cmd          = '0;
      cmd.s        = step_ff;
      cmd.clr_addr = clr_ff;
      pass_end     = (sts.multi_row && step_ff[0]) || (step_ff == 4'hF);
      if (!pass_end) begin
         adv_state = S_STEP;
      end else if (sts.wb_need) begin
         adv_state = S_WB;
      end else if (step_ff == 4'hF) begin
         adv_state = S_FIN_RD;
      end else begin
         adv_state = S_ROW_RD;
      end
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_en = 1'b1;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == vlsu_pkg::DMEM_AW'(vlsu_pkg::DMEM_BYTES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               step_in    = 4'd0;
               state_in   = S_ROW_RD;
            end
         end
         S_ROW_RD: begin
            cmd.row_rd = 1'b1;
            state_in   = S_ROW_CAP;
         end
         S_ROW_CAP: begin
            cmd.row_cap = 1'b1;
            state_in    = S_STEP;
         end
         S_STEP: begin
            cmd.step = 1'b1;
            if (sts.act && sts.rd) begin
               state_in = S_APPLY;
            end else begin
               step_in  = step_ff + 1'b1;
               state_in = adv_state;
            end
         end
         S_APPLY: begin
            cmd.apply = 1'b1;
            step_in   = step_ff + 1'b1;
            state_in  = adv_state;
         end
         S_WB: begin
            cmd.wb   = 1'b1;
            state_in = (step_ff == 4'd0) ? S_FIN_RD : S_ROW_RD;
         end
         S_FIN_RD: begin
            cmd.fin_rd = 1'b1;
            state_in   = S_FIN_CAP;
         end
         S_FIN_CAP: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.fin_cap  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         step_ff      <= 4'd0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_idle_step_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (step_ff == 4'd0))
      else $error("step counter not back at zero in idle");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_FIN_CAP))
      else $error("result word raised outside final capture");

   a_wb_needed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WB) |-> sts.wb_need)
      else $error("row write-back for a command that leaves rows alone");

endmodule

>>> hdl/vlsu_dpath.sv
// ----------------------------------------------------------------------------
// vlsu_dpath
// Data memory, vector register file, one-row working buffer, command
// registers and the result register of the load/store unit.
// ----------------------------------------------------------------------------
module vlsu_dpath (
   input  logic                   clock,
   input  vlsu_pkg::ctrl_cmd_type cmd,
   output vlsu_pkg::ctrl_sts_type sts,
   input  logic [4:0]             req_cmd,
   input  logic [11:0]            req_addr,
   input  logic [4:0]             req_vreg,
   input  logic [3:0]             req_element,
   input  logic [31:0]            req_store_data,
   input  logic [63:0]            req_vec_in_high,
   input  logic [63:0]            req_vec_in_low,
   output logic [31:0]            rsp_load_data,
   output logic [63:0]            rsp_vec_out_high,
   output logic [63:0]            rsp_vec_out_low
);

   logic [7:0]   dmem [vlsu_pkg::DMEM_BYTES];
   logic [127:0] vmem [vlsu_pkg::VREG_COUNT];

   logic [4:0]   op_ff, op_in;
   logic [11:0]  addr_ff, addr_in;
   logic [4:0]   vreg_ff, vreg_in;
   logic [3:0]   elem_ff, elem_in;
   logic [31:0]  sdata_ff, sdata_in;
   logic [127:0] vin_ff, vin_in;
   logic [7:0]   w_ff [16];
   logic [7:0]   w_in [16];
   logic [31:0]  ld_ff, ld_in;
   logic [7:0]   dq_ff;
   logic [127:0] vq_ff;
   logic [vlsu_pkg::VREG_AW-1:0] wrow_ff, wrow_in;
   logic [31:0]  out_ld_ff;
   logic [127:0] out_vec_ff;

   vlsu_pkg::step_plan_type plan;
   logic [3:0]   bnext;
   logic [7:0]   st_val;
   logic         dm_we;
   logic [vlsu_pkg::DMEM_AW-1:0] dm_wa;
   logic [7:0]   dm_wd;
   logic         dm_re;
   logic         vm_we;
   logic [vlsu_pkg::VREG_AW-1:0] vm_wa;
   logic [127:0] vm_wd;
   logic         vm_re;
   logic [vlsu_pkg::VREG_AW-1:0] vm_ra;

   assign plan  = vlsu_pkg::step_plan(op_ff, addr_ff, vreg_ff, elem_ff, cmd.s);
   assign bnext = plan.bidx + 4'd1;

   // status back to the sequencer
   assign sts.act       = plan.act;
   assign sts.rd        = plan.rd;
   assign sts.wb_need   = (op_ff inside {[vlsu_pkg::CMD_LBV:vlsu_pkg::CMD_LTV]})
                          || (op_ff == vlsu_pkg::CMD_VWRITE);
   assign sts.multi_row = (op_ff == vlsu_pkg::CMD_LTV) || (op_ff == vlsu_pkg::CMD_STV);

   // capture the command word
   always_comb begin
      op_in    = op_ff;
      addr_in  = addr_ff;
      vreg_in  = vreg_ff;
      elem_in  = elem_ff;
      sdata_in = sdata_ff;
      vin_in   = vin_ff;
      if (cmd.accept) begin
         op_in    = req_cmd;
         addr_in  = req_addr;
         vreg_in  = req_vreg;
         elem_in  = req_element;
         sdata_in = req_store_data;
         vin_in   = {req_vec_in_high, req_vec_in_low};
      end
   end

   // store byte for this step
   always_comb begin
      case (plan.mode)
         vlsu_pkg::M_ST_DATA: begin
            case (plan.bidx[1:0])
               2'd0:    st_val = sdata_ff[7:0];
               2'd1:    st_val = sdata_ff[15:8];
               2'd2:    st_val = sdata_ff[23:16];
               default: st_val = sdata_ff[31:24];
            endcase
         end
         vlsu_pkg::M_ST_BYTE: st_val = w_ff[plan.bidx];
         vlsu_pkg::M_ST_SHL:  st_val = {w_ff[plan.bidx][6:0], w_ff[bnext][7]};
         default:             st_val = 8'd0;
      endcase
   end

   // working row and scalar accumulator
   always_comb begin
      w_in    = w_ff;
      ld_in   = ld_ff;
      wrow_in = wrow_ff;
      if (cmd.accept) begin
         ld_in = 32'd0;
      end
      if (cmd.row_rd) begin
         wrow_in = plan.row;
      end
      if (cmd.row_cap) begin
         for (int j = 0; j < 16; j++) begin
            if (op_ff == vlsu_pkg::CMD_VWRITE) begin
               w_in[j] = vin_ff[127 - 8 * j -: 8];
            end else begin
               w_in[j] = vq_ff[127 - 8 * j -: 8];
            end
         end
      end
      if (cmd.apply && plan.act) begin
         case (plan.mode)
            vlsu_pkg::M_LD_SCALAR: ld_in = {ld_ff[23:0], dq_ff};
            vlsu_pkg::M_LD_BYTE:   w_in[plan.bidx] = dq_ff;
            vlsu_pkg::M_LD_HALF8: begin
               if (plan.en_hi) w_in[plan.bidx] = dq_ff;
               if (plan.en_lo) w_in[bnext] = 8'd0;
            end
            vlsu_pkg::M_LD_HALF7: begin
               if (plan.en_hi) w_in[plan.bidx] = {1'b0, dq_ff[7:1]};
               if (plan.en_lo) w_in[bnext] = {dq_ff[0], 7'd0};
            end
            default: begin
            end
         endcase
      end
   end

   // memory port selection
   always_comb begin
      dm_we = cmd.clr_en || (cmd.step && plan.act && plan.wr);
      dm_wa = cmd.clr_en ? cmd.clr_addr : plan.maddr;
      dm_wd = cmd.clr_en ? 8'd0 : st_val;
      dm_re = cmd.step && plan.act && plan.rd;
      vm_we = (cmd.clr_en &&
               (cmd.clr_addr[vlsu_pkg::DMEM_AW-1:vlsu_pkg::VREG_AW] == '0)) || cmd.wb;
      vm_wa = cmd.clr_en ? cmd.clr_addr[vlsu_pkg::VREG_AW-1:0] : wrow_ff;
      vm_re = cmd.row_rd || cmd.fin_rd;
      vm_ra = cmd.row_rd ? plan.row : vreg_ff[vlsu_pkg::VREG_AW-1:0];
      for (int j = 0; j < 16; j++) begin
         vm_wd[127 - 8 * j -: 8] = cmd.clr_en ? 8'd0 : w_ff[j];
      end
   end

   // data memory
   always_ff @(posedge clock) begin
      if (dm_we) begin
         dmem[dm_wa] <= dm_wd;
      end
      if (dm_re) begin
         dq_ff <= dmem[plan.maddr];
      end
   end

   // vector register file
   always_ff @(posedge clock) begin
      if (vm_we) begin
         vmem[vm_wa] <= vm_wd;
      end
      if (vm_re) begin
         vq_ff <= vmem[vm_ra];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      addr_ff  <= addr_in;
      vreg_ff  <= vreg_in;
      elem_ff  <= elem_in;
      sdata_ff <= sdata_in;
      vin_ff   <= vin_in;
      w_ff     <= w_in;
      ld_ff    <= ld_in;
      wrow_ff  <= wrow_in;
      if (cmd.fin_cap) begin
         out_ld_ff  <= ld_ff;
         out_vec_ff <= vq_ff;
      end
   end

   assign rsp_load_data    = out_ld_ff;
   assign rsp_vec_out_high = out_vec_ff[127:64];
   assign rsp_vec_out_low  = out_vec_ff[63:0];

endmodule

>>> hdl/vector_load_store_unit_top.sv
// ----------------------------------------------------------------------------
// vector_load_store_unit_top
// Vector load/store unit between a big-endian byte data memory and the
// vector register file; one result word per command word.
// ----------------------------------------------------------------------------
// Throughput: one command word at a time; the single data memory port moves
//   one byte per step, sixteen steps per command; a load step adds an apply state.
// Reset: a clearing sweep zeroes data memory and registers; no command word
//   is taken until it ends.
module vector_load_store_unit_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [4:0]  req_cmd,
   input  logic [11:0] req_addr,
   input  logic [4:0]  req_vreg,
   input  logic [3:0]  req_element,
   input  logic [31:0] req_store_data,
   input  logic [63:0] req_vec_in_high,
   input  logic [63:0] req_vec_in_low,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_load_data,
   output logic [63:0] rsp_vec_out_high,
   output logic [63:0] rsp_vec_out_low
);

   vlsu_pkg::ctrl_cmd_type cmd;
   vlsu_pkg::ctrl_sts_type sts;

   // sequencer
   vlsu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // storage and byte datapath
   vlsu_dpath u_dpath (
      .clock            (clock),
      .cmd              (cmd),
      .sts              (sts),
      .req_cmd          (req_cmd),
      .req_addr         (req_addr),
      .req_vreg         (req_vreg),
      .req_element      (req_element),
      .req_store_data   (req_store_data),
      .req_vec_in_high  (req_vec_in_high),
      .req_vec_in_low   (req_vec_in_low),
      .rsp_load_data    (rsp_load_data),
      .rsp_vec_out_high (rsp_vec_out_high),
      .rsp_vec_out_low  (rsp_vec_out_low)
   );

endmodule
